/* hdl/id3v2_tag_stream_parser_core_defines.svh */
// Assertion macros shared by the checker of the ID3v2 tag stream parser.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ID3V2_TAG_STREAM_PARSER_CORE_DEFINES_SVH
`define ID3V2_TAG_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ID3P_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("id3p: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ID3P_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("id3p: next-cycle check failed");

// Next-cycle implication that is checked through reset as well.
`define ID3P_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("id3p: reset check failed");

`endif

/* hdl/id3p_pkg.sv */
// Types and constants of the ID3v2 tag stream parser.
// Used by the core and by its checker; depends on nothing.
package id3p_pkg;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_EXT  = 3'd1;
  localparam logic [2:0] PH_FHDR = 3'd2;
  localparam logic [2:0] PH_BODY = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_REJ  = 3'd5;

  localparam logic [7:0] MAGIC_0 = 8'h49;
  localparam logic [7:0] MAGIC_1 = 8'h44;
  localparam logic [7:0] MAGIC_2 = 8'h33;

  localparam logic [3:0] MAGIC_LEN      = 4'd3;
  localparam logic [3:0] HDR_FLAGS_IDX  = 4'd5;
  localparam logic [3:0] HDR_SIZE_IDX   = 4'd6;
  localparam logic [3:0] HDR_LAST_IDX   = 4'd9;
  localparam logic [3:0] EXT_SIZE_LEN   = 4'd4;
  localparam logic [3:0] EXT_FLAGS_IDX  = 4'd4;
  localparam logic [3:0] EXT_LAST_IDX   = 4'd5;
  localparam logic [3:0] EXT_CRC_LAST   = 4'd9;
  localparam logic [3:0] FRM_ID_LEN     = 4'd4;
  localparam logic [3:0] FRM_SIZE_END   = 4'd8;
  localparam logic [3:0] FRM_LAST_IDX   = 4'd9;
  localparam logic [32:0] FRM_HDR_BYTES = 33'd10;
  localparam logic [15:0] FRAME_NUM_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [31:0] frame_id;
    logic [31:0] frame_body_len;
    logic        frame_header_done;
    logic        body_last;
    logic [15:0] frame_number;
    logic [27:0] tag_size;
    logic        has_extended;
    logic        tag_end;
    logic        size_overrun;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0: val = MAGIC_0;
      2'd1: val = MAGIC_1;
      2'd2: val = MAGIC_2;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

/* hdl/id3v2_tag_stream_parser_core.sv */
// ID3v2.3 tag stream parser: labels the role of each byte of a tag.
// Depends on id3p_pkg for the phase codes and the result structure.
//
// Usage: bytes enter on the input channel (in_valid/in_ready with data_byte
// and restart), one transaction per byte, starting at the first tag byte.
// Restart set with a byte clears all parse state before that byte is used.
// Each byte yields exactly one result transaction on the output channel
// (out_valid/out_ready) carrying its role, the current frame id and size,
// frame and tag markers, the frame number and the decoded tag size.
// Each result is registered in the result register or, on a stall, the skid entry.
// Throughput: one byte per cycle while in_ready is high; the per-byte update
// of the parse counters and the remaining-size compare and subtract sit
// between the parse state and the result register.
// Stall: a result register and one skid entry hold up to two results; in_ready
// is low while both are full and rises in the cycle after the receiver takes one.
// Reset: rst clears the parse state and both result entries; the first
// byte after reset is treated as tag byte 0.
module id3v2_tag_stream_parser_core
  import id3p_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_role,
  output logic [31:0] frame_id,
  output logic [31:0] frame_body_len,
  output logic        frame_header_done,
  output logic        body_last,
  output logic [15:0] frame_number,
  output logic [27:0] tag_size,
  output logic        has_extended,
  output logic        tag_end,
  output logic        size_overrun
);

  logic [2:0]  phase;
  logic [3:0]  section_count;
  logic [27:0] size_accum;
  logic [31:0] remaining_bytes;
  logic [31:0] id_shift;
  logic [31:0] cur_frame_len;
  logic [31:0] body_left;
  logic        ext_present;
  logic        crc_present;
  logic [31:0] ext_len;
  logic [15:0] frame_counter;

  logic [2:0]  phase_next;
  logic [3:0]  section_count_next;
  logic [27:0] size_accum_next;
  logic [31:0] remaining_bytes_next;
  logic [31:0] id_shift_next;
  logic [31:0] cur_frame_len_next;
  logic [31:0] body_left_next;
  logic        ext_present_next;
  logic        crc_present_next;
  logic [31:0] ext_len_next;
  logic [15:0] frame_counter_next;

  logic [2:0]  cur_phase;
  logic [3:0]  cur_count;
  logic [27:0] cur_accum;
  logic [31:0] cur_remaining;
  logic [31:0] cur_id;
  logic [31:0] cur_len;
  logic [31:0] cur_body;
  logic        cur_ext;
  logic        cur_crc;
  logic [31:0] cur_ext_len;
  logic [15:0] cur_counter;

  logic [32:0] frame_total;
  logic [3:0]  ext_last;
  logic        enter_frames;
  logic        finish_frame;
  result_t     res;
  result_t     out_res;
  result_t     skid_res;
  logic        skid_full;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_full;

  always_comb begin
    if (restart) begin
      cur_phase     = PH_HDR;
      cur_count     = '0;
      cur_accum     = '0;
      cur_remaining = '0;
      cur_id        = '0;
      cur_len       = '0;
      cur_body      = '0;
      cur_ext       = 1'b0;
      cur_crc       = 1'b0;
      cur_ext_len   = '0;
      cur_counter   = '0;
    end else begin
      cur_phase     = phase;
      cur_count     = section_count;
      cur_accum     = size_accum;
      cur_remaining = remaining_bytes;
      cur_id        = id_shift;
      cur_len       = cur_frame_len;
      cur_body      = body_left;
      cur_ext       = ext_present;
      cur_crc       = crc_present;
      cur_ext_len   = ext_len;
      cur_counter   = frame_counter;
    end
  end

  always_comb begin
    phase_next           = cur_phase;
    section_count_next   = cur_count;
    size_accum_next      = cur_accum;
    remaining_bytes_next = cur_remaining;
    id_shift_next        = cur_id;
    cur_frame_len_next   = cur_len;
    body_left_next       = cur_body;
    ext_present_next     = cur_ext;
    crc_present_next     = cur_crc;
    ext_len_next         = cur_ext_len;
    frame_counter_next   = cur_counter;
    enter_frames         = 1'b0;
    finish_frame         = 1'b0;
    frame_total          = '0;
    ext_last             = EXT_LAST_IDX;
    res                  = '0;
    res.byte_role        = cur_phase;
    res.frame_number     = cur_counter;

    case (cur_phase)
      PH_HDR: begin
        if (cur_count < MAGIC_LEN && data_byte != magic_byte(cur_count[1:0])) begin
          phase_next    = PH_REJ;
          res.byte_role = PH_REJ;
        end else begin
          if (cur_count == HDR_FLAGS_IDX) begin
            ext_present_next = data_byte[6];
          end else if (cur_count >= HDR_SIZE_IDX) begin
            size_accum_next = {cur_accum[20:0], data_byte[6:0]};
          end
          if (cur_count >= HDR_LAST_IDX) begin
            remaining_bytes_next = {4'b0000, size_accum_next};
            section_count_next   = '0;
            if (ext_present_next) begin
              phase_next = PH_EXT;
            end else begin
              enter_frames = 1'b1;
            end
          end else begin
            section_count_next = cur_count + 4'd1;
          end
        end
      end
      PH_EXT: begin
        if (cur_count < EXT_SIZE_LEN) begin
          ext_len_next = {cur_ext_len[23:0], data_byte};
        end else if (cur_count == EXT_FLAGS_IDX) begin
          crc_present_next = data_byte[7];
        end
        ext_last = crc_present_next ? EXT_CRC_LAST : EXT_LAST_IDX;
        if (cur_count >= ext_last) begin
          if (ext_len_next > cur_remaining) begin
            res.size_overrun     = 1'b1;
            remaining_bytes_next = '0;
          end else begin
            remaining_bytes_next = cur_remaining - ext_len_next;
          end
          enter_frames = 1'b1;
        end else begin
          section_count_next = cur_count + 4'd1;
        end
      end
      PH_FHDR: begin
        if (cur_count < FRM_ID_LEN && data_byte == 8'h00) begin
          phase_next         = PH_DONE;
          res.byte_role      = PH_DONE;
          res.tag_end        = 1'b1;
          section_count_next = '0;
        end else begin
          if (cur_count == 4'd0) begin
            id_shift_next      = {24'h000000, data_byte};
            cur_frame_len_next = '0;
          end else if (cur_count < FRM_ID_LEN) begin
            id_shift_next = {cur_id[23:0], data_byte};
          end else if (cur_count < FRM_SIZE_END) begin
            cur_frame_len_next = {cur_len[23:0], data_byte};
          end
          if (cur_count >= FRM_LAST_IDX) begin
            frame_total           = {1'b0, cur_frame_len_next} + FRM_HDR_BYTES;
            res.frame_header_done = 1'b1;
            if (frame_total > {1'b0, cur_remaining}) begin
              res.size_overrun     = 1'b1;
              remaining_bytes_next = '0;
            end else begin
              remaining_bytes_next = cur_remaining - frame_total[31:0];
            end
            body_left_next     = cur_frame_len_next;
            section_count_next = '0;
            if (cur_frame_len_next == '0) begin
              finish_frame = 1'b1;
            end else begin
              phase_next = PH_BODY;
            end
          end else begin
            section_count_next = cur_count + 4'd1;
          end
        end
      end
      PH_BODY: begin
        if (cur_body <= 32'd1) begin
          body_left_next = '0;
          res.body_last  = 1'b1;
          finish_frame   = 1'b1;
        end else begin
          body_left_next = cur_body - 32'd1;
        end
      end
      PH_DONE: begin
        res.byte_role = PH_DONE;
      end
      default: begin
        phase_next    = PH_REJ;
        res.byte_role = PH_REJ;
      end
    endcase

    if (finish_frame) begin
      enter_frames = 1'b1;
      if (cur_counter < FRAME_NUM_MAX) begin
        frame_counter_next = cur_counter + 16'd1;
      end
    end
    if (enter_frames) begin
      section_count_next = '0;
      if (remaining_bytes_next == '0) begin
        phase_next  = PH_DONE;
        res.tag_end = 1'b1;
      end else begin
        phase_next = PH_FHDR;
      end
    end

    res.frame_id       = id_shift_next;
    res.frame_body_len = cur_frame_len_next;
    res.tag_size       = size_accum_next;
    res.has_extended   = ext_present_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      section_count   <= '0;
      size_accum      <= '0;
      remaining_bytes <= '0;
      id_shift        <= '0;
      cur_frame_len   <= '0;
      body_left       <= '0;
      ext_present     <= 1'b0;
      crc_present     <= 1'b0;
      ext_len         <= '0;
      frame_counter   <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      section_count   <= section_count_next;
      size_accum      <= size_accum_next;
      remaining_bytes <= remaining_bytes_next;
      id_shift        <= id_shift_next;
      cur_frame_len   <= cur_frame_len_next;
      body_left       <= body_left_next;
      ext_present     <= ext_present_next;
      crc_present     <= crc_present_next;
      ext_len         <= ext_len_next;
      frame_counter   <= frame_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_full) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign byte_role         = out_res.byte_role;
  assign frame_id          = out_res.frame_id;
  assign frame_body_len    = out_res.frame_body_len;
  assign frame_header_done = out_res.frame_header_done;
  assign body_last         = out_res.body_last;
  assign frame_number      = out_res.frame_number;
  assign tag_size          = out_res.tag_size;
  assign has_extended      = out_res.has_extended;
  assign tag_end           = out_res.tag_end;
  assign size_overrun      = out_res.size_overrun;

endmodule

/* hdl/id3p_checker.sv */
// Port-level checker for the ID3v2 tag stream parser, bound to the core.
// Depends on id3p_pkg and on the assertion macros of the defines header.
`include "id3v2_tag_stream_parser_core_defines.svh"

module id3p_checker
  import id3p_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  byte_role,
  input logic [31:0] frame_id,
  input logic [31:0] frame_body_len,
  input logic        frame_header_done,
  input logic        body_last,
  input logic [15:0] frame_number
);

  `ID3P_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(byte_role) && $stable(frame_id) && $stable(frame_body_len)
    && $stable(frame_number))

  `ID3P_ASSERT_IMPLY(a_hdone_role, clk, rst, out_valid && frame_header_done, byte_role == PH_FHDR)

  `ID3P_ASSERT_IMPLY(a_blast_role, clk, rst, out_valid && body_last, byte_role == PH_BODY && !frame_header_done)

  `ID3P_ASSERT_NEXT(a_skid_holds, clk, rst, !in_ready && out_valid && !out_ready, !in_ready)

  `ID3P_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !out_valid && in_ready)

endmodule

bind id3v2_tag_stream_parser_core id3p_checker u_id3p_checker (.*);
